// ----- rtl/core/htbp_pkg.sv -----
// ----------------------------------------------------------------------------
// htbp_pkg: shared types and constants of the hex text byte parser
// Holds the character class record that flows from the front end through the
// queue to the parse engine, the result codes and the hex digit decoder.
// ----------------------------------------------------------------------------
package htbp_pkg;

  // Default byte limit and queue depth.
  localparam int unsigned MAX_BYTES_DEF   = 1024;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Result kinds.
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Error causes.
  localparam logic [1:0] CAUSE_BAD_COMMENT = 2'd0;
  localparam logic [1:0] CAUSE_BAD_HEX     = 2'd1;
  localparam logic [1:0] CAUSE_LIMIT       = 2'd2;
  localparam logic [1:0] CAUSE_END_COMMENT = 2'd3;

  // Character codes the parser reacts to.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;

  // One classified character, as queued between front end and engine.
  typedef struct packed {
    logic       new_text;
    logic       is_nul;
    logic       is_end;
    logic       is_slash;
    logic       is_star;
    logic       is_lbrk;
    logic       is_space;
    logic       is_eol;
    logic       is_hex;
    logic [3:0] hex_val;
  } char_item_t;

  // Returns {valid, value} for an ASCII hex digit.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/hex_text_byte_parser.sv -----
// ----------------------------------------------------------------------------
// hex_text_byte_parser: streaming parser for a bracketed list of hex bytes
// Takes one text character per beat and produces data, done and error beats.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle, sustained while the output is taken.
// Path: an accepted character is written into the queue, and its result is
//   then held in the engine's output register.
// Rate is set by the engine, which updates its parse state for every character.
// Reset: rst_ni clears the queue, the parse state and the output register.
module hex_text_byte_parser
  import htbp_pkg::*;
#(
  parameter int unsigned MaxBytes   = MAX_BYTES_DEF,
  parameter int unsigned QueueDepth = QUEUE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_code_i,
  input  logic       new_text_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [7:0] data_byte_o,
  output logic [9:0] byte_count_o,
  output logic [1:0] error_cause_o
);

  localparam int unsigned ItemW = $bits(char_item_t);

  // The front end only classifies, so each input beat is written into the
  // queue in the cycle it is accepted. The queue lets the front end keep
  // taking characters, up to QueueDepth of them, while a result beat waits at
  // the output.
  char_item_t front_item;
  char_item_t back_item;
  logic       back_valid;
  logic       back_ready;

  htbp_classify u_classify (
    .char_code_i (char_code_i),
    .new_text_i  (new_text_i),
    .item_o      (front_item)
  );

  htbp_fifo #(
    .Width (ItemW),
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_data_i  (front_item),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_data_o   (back_item)
  );

  // The engine takes a queued character whenever its output register is
  // empty or being drained in the same cycle, so results stream at full rate.
  htbp_engine #(
    .MaxBytes (MaxBytes)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (back_valid),
    .item_ready_o  (back_ready),
    .item_i        (back_item),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .data_byte_o   (data_byte_o),
    .byte_count_o  (byte_count_o),
    .error_cause_o (error_cause_o)
  );

  // A data beat never carries an error cause.
  a_data_no_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_DATA) |-> (error_cause_o == CAUSE_BAD_COMMENT))
    else $error("data beat with nonzero error cause");

  // A done beat carries no byte and no cause.
  a_done_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_DONE) |->
      (data_byte_o == 8'd0) && (error_cause_o == CAUSE_BAD_COMMENT))
    else $error("done beat with byte or cause set");

  // The limit error always reports the count just below the limit.
  a_limit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_ERROR) && (error_cause_o == CAUSE_LIMIT) |->
      (byte_count_o == 10'(MaxBytes - 1)))
    else $error("limit error with wrong byte count");

endmodule

// ----- rtl/core/htbp_classify.sv -----
// ----------------------------------------------------------------------------
// htbp_classify: front end character classifier
// Sorts each accepted character into the classes the engine acts on and
// decodes its hex value, so the engine sees only a few flag bits.
// ----------------------------------------------------------------------------
module htbp_classify
  import htbp_pkg::*;
(
  input  logic [7:0]  char_code_i,
  input  logic        new_text_i,
  output char_item_t  item_o
);

  logic [4:0] hex;

  assign hex = hex_decode(char_code_i);

  always_comb begin
    item_o.new_text = new_text_i;
    item_o.is_nul   = (char_code_i == CH_NUL);
    item_o.is_end   = (char_code_i == CH_NUL) || (char_code_i == CH_RBRK) ||
                      (char_code_i == CH_SEMI);
    item_o.is_slash = (char_code_i == CH_SLASH);
    item_o.is_star  = (char_code_i == CH_STAR);
    item_o.is_lbrk  = (char_code_i == CH_LBRK);
    item_o.is_eol   = (char_code_i == CH_LF) || (char_code_i == CH_CR);
    item_o.is_space = (char_code_i == CH_SPACE) || (char_code_i == CH_TAB) ||
                      (char_code_i == CH_LF) || (char_code_i == CH_VT) ||
                      (char_code_i == CH_FF) || (char_code_i == CH_CR);
    item_o.is_hex   = hex[4];
    item_o.hex_val  = hex[3:0];
  end

endmodule

// ----- rtl/core/htbp_fifo.sv -----
// ----------------------------------------------------------------------------
// htbp_fifo: small register queue between front end and engine
// Depth must be a power of two, at least two.
// ----------------------------------------------------------------------------
module htbp_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [Width-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [Width-1:0] pop_data_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/core/htbp_engine.sv -----
// ----------------------------------------------------------------------------
// htbp_engine: back end parse state machine and result register
// Consumes one classified character per cycle while its output register is
// free or being drained, and holds at most one result beat in that register until the consumer takes it.
// ----------------------------------------------------------------------------
module htbp_engine
  import htbp_pkg::*;
#(
  parameter int unsigned MaxBytes = MAX_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       item_valid_i,
  output logic       item_ready_o,
  input  char_item_t item_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [7:0] data_byte_o,
  output logic [9:0] byte_count_o,
  output logic [1:0] error_cause_o
);

  localparam int unsigned CntW = $clog2(MaxBytes);
  localparam logic [CntW-1:0] LastCnt = CntW'(MaxBytes - 1);

  typedef enum logic [2:0] {
    PH_NORMAL,
    PH_SLASH,
    PH_BLOCK,
    PH_BLOCK_STAR,
    PH_LINE,
    PH_HEX2
  } phase_e;

  phase_e          phase_q, phase_d, ph;
  logic            in_data_q, in_data_d, indata;
  logic [3:0]      hnib_q, hnib_d, hn;
  logic [CntW-1:0] count_q, count_d, cnt;
  logic            fin_q, fin_d, fin;

  logic            out_valid_q;
  logic [1:0]      kind_q, kind_d;
  logic [7:0]      byte_q, byte_d;
  logic [9:0]      bcnt_q, bcnt_d;
  logic [1:0]      cause_q, cause_d;
  logic            emit;
  logic            take;

  assign item_ready_o  = !out_valid_q || out_ready_i;
  assign take          = item_valid_i && item_ready_o;
  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign data_byte_o   = byte_q;
  assign byte_count_o  = bcnt_q;
  assign error_cause_o = cause_q;

  always_comb begin
    // A new text clears the state before this character is handled.
    ph     = item_i.new_text ? PH_NORMAL : phase_q;
    indata = item_i.new_text ? 1'b0 : in_data_q;
    hn     = item_i.new_text ? 4'd0 : hnib_q;
    cnt    = item_i.new_text ? '0 : count_q;
    fin    = item_i.new_text ? 1'b0 : fin_q;

    phase_d   = ph;
    in_data_d = indata;
    hnib_d    = hn;
    count_d   = cnt;
    emit      = 1'b0;
    kind_d    = KIND_DONE;
    byte_d    = 8'd0;
    bcnt_d    = 10'(cnt);
    cause_d   = CAUSE_BAD_COMMENT;

    if (!fin) begin
      case (ph)
        PH_SLASH: begin
          if (item_i.is_star) begin
            phase_d = PH_BLOCK;
          end else if (item_i.is_slash) begin
            phase_d = PH_LINE;
          end else begin
            emit    = 1'b1;
            kind_d  = KIND_ERROR;
            cause_d = CAUSE_BAD_COMMENT;
          end
        end
        PH_BLOCK: begin
          if (item_i.is_nul) begin
            emit    = 1'b1;
            kind_d  = KIND_ERROR;
            cause_d = CAUSE_END_COMMENT;
          end else if (item_i.is_star) begin
            phase_d = PH_BLOCK_STAR;
          end
        end
        PH_BLOCK_STAR: begin
          if (item_i.is_nul) begin
            emit    = 1'b1;
            kind_d  = KIND_ERROR;
            cause_d = CAUSE_END_COMMENT;
          end else if (item_i.is_slash) begin
            phase_d = PH_NORMAL;
          end else if (!item_i.is_star) begin
            phase_d = PH_BLOCK;
          end
        end
        PH_LINE: begin
          if (item_i.is_nul) begin
            emit    = 1'b1;
            kind_d  = KIND_ERROR;
            cause_d = CAUSE_END_COMMENT;
          end else if (item_i.is_eol) begin
            phase_d = PH_NORMAL;
          end
        end
        PH_HEX2: begin
          emit = 1'b1;
          if (!item_i.is_hex) begin
            kind_d  = KIND_ERROR;
            cause_d = CAUSE_BAD_HEX;
          end else begin
            phase_d = PH_NORMAL;
            hnib_d  = 4'd0;
            byte_d  = {hn, item_i.hex_val};
            if (cnt == LastCnt) begin
              // The byte that reaches the limit is reported in the error.
              kind_d  = KIND_ERROR;
              cause_d = CAUSE_LIMIT;
              bcnt_d  = 10'(LastCnt);
            end else begin
              count_d = cnt + CntW'(1);
              kind_d  = KIND_DATA;
              bcnt_d  = 10'(cnt + CntW'(1));
            end
          end
        end
        default: begin
          phase_d = PH_NORMAL;
          if (item_i.is_end) begin
            emit   = 1'b1;
            kind_d = KIND_DONE;
          end else if (item_i.is_slash) begin
            phase_d = PH_SLASH;
          end else if (!indata) begin
            if (item_i.is_lbrk) begin
              in_data_d = 1'b1;
            end
          end else if (item_i.is_space) begin
            phase_d = PH_NORMAL;
          end else if (item_i.is_hex) begin
            hnib_d  = item_i.hex_val;
            phase_d = PH_HEX2;
          end else begin
            emit    = 1'b1;
            kind_d  = KIND_ERROR;
            cause_d = CAUSE_BAD_HEX;
          end
        end
      endcase
    end

    fin_d = fin || (emit && (kind_d != KIND_DATA));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_NORMAL;
      in_data_q   <= 1'b0;
      hnib_q      <= 4'd0;
      count_q     <= '0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
      kind_q      <= KIND_DATA;
      byte_q      <= 8'd0;
      bcnt_q      <= 10'd0;
      cause_q     <= CAUSE_BAD_COMMENT;
    end else begin
      // A new result refills the register in the cycle the old one drains.
      if (take && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (take) begin
        phase_q   <= phase_d;
        in_data_q <= in_data_d;
        hnib_q    <= hnib_d;
        count_q   <= count_d;
        fin_q     <= fin_d;
        if (emit) begin
          kind_q      <= kind_d;
          byte_q      <= byte_d;
          bcnt_q      <= bcnt_d;
          cause_q     <= cause_d;
        end
      end
    end
  end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the hex text byte parser
// Feeds text characters through the valid/ready input channel. A scoreboard
// class predicts the data, done and error beats. Every output beat is checked
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import htbp_pkg::*;

  // The run is ended as a failure if it is still going after this many cycles.
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  // The least number of random characters that the parser actually acts on.
  localparam int unsigned RANDOM_CHARS  = 1400;
  // Cycles allowed for a stray beat to show up once nothing is expected.
  localparam int unsigned DRAIN_CYCLES  = 30;

  // Scan states of the parser as the predictor tracks them.
  typedef enum logic [2:0] {
    ST_SCAN,
    ST_SLASH,
    ST_BLOCK,
    ST_BLOCK_STAR,
    ST_LINE,
    ST_LOW_NIBBLE
  } scan_state_e;

  typedef struct {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [9:0] byte_count;
    logic [1:0] error_cause;
  } parse_beat_t;

  // Predicts the parser's beats and checks what comes out of it.
  class parse_scoreboard;
    parse_beat_t pending_beats[$];
    scan_state_e state;
    bit          in_data;
    logic [3:0]  high_nibble;
    int unsigned bytes_seen;
    bit          finished;
    int unsigned mismatches;

    function new();
      clear();
      mismatches = 0;
    endfunction

    function void clear();
      state       = ST_SCAN;
      in_data     = 1'b0;
      high_nibble = 4'd0;
      bytes_seen  = 0;
      finished    = 1'b0;
    endfunction

    function int pending();
      return pending_beats.size();
    endfunction

    function void report(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      mismatches++;
    endfunction

    function int digit_of(logic [7:0] c);
      if (c >= "0" && c <= "9") begin
        return int'(c) - int'("0");
      end else if (c >= "a" && c <= "f") begin
        return int'(c) - int'("a") + 10;
      end else if (c >= "A" && c <= "F") begin
        return int'(c) - int'("A") + 10;
      end
      return -1;
    endfunction

    function void add_beat(logic [1:0] kind, logic [7:0] data_byte, int unsigned cnt,
                           logic [1:0] cause);
      parse_beat_t b;
      b.kind        = kind;
      b.data_byte   = data_byte;
      b.byte_count  = 10'(cnt);
      b.error_cause = cause;
      pending_beats.push_back(b);
      if (kind != KIND_DATA) begin
        finished = 1'b1;
      end
    endfunction

    // Notes one accepted character. Returns 1 unless the parser ignores it.
    function bit predict_char(logic [7:0] c, logic fresh);
      int         dv;
      logic [7:0] full_byte;
      if (fresh) begin
        clear();
      end
      if (finished) begin
        return 1'b0;
      end
      dv = digit_of(c);
      case (state)
        ST_SLASH: begin
          if (c == CH_STAR) begin
            state = ST_BLOCK;
          end else if (c == CH_SLASH) begin
            state = ST_LINE;
          end else begin
            add_beat(KIND_ERROR, 8'd0, bytes_seen, CAUSE_BAD_COMMENT);
          end
          return 1'b1;
        end
        ST_BLOCK: begin
          if (c == CH_NUL) begin
            add_beat(KIND_ERROR, 8'd0, bytes_seen, CAUSE_END_COMMENT);
          end else if (c == CH_STAR) begin
            state = ST_BLOCK_STAR;
          end
          return 1'b1;
        end
        ST_BLOCK_STAR: begin
          if (c == CH_NUL) begin
            add_beat(KIND_ERROR, 8'd0, bytes_seen, CAUSE_END_COMMENT);
          end else if (c == CH_SLASH) begin
            state = ST_SCAN;
          end else if (c != CH_STAR) begin
            state = ST_BLOCK;
          end
          return 1'b1;
        end
        ST_LINE: begin
          if (c == CH_NUL) begin
            add_beat(KIND_ERROR, 8'd0, bytes_seen, CAUSE_END_COMMENT);
          end else if (c == CH_LF || c == CH_CR) begin
            state = ST_SCAN;
          end
          return 1'b1;
        end
        ST_LOW_NIBBLE: begin
          if (dv < 0) begin
            add_beat(KIND_ERROR, 8'd0, bytes_seen, CAUSE_BAD_HEX);
          end else begin
            full_byte   = {high_nibble, 4'(dv)};
            state       = ST_SCAN;
            high_nibble = 4'd0;
            bytes_seen++;
            // The byte that reaches the limit is reported as an error instead.
            if (bytes_seen >= MAX_BYTES_DEF) begin
              add_beat(KIND_ERROR, full_byte, MAX_BYTES_DEF - 1, CAUSE_LIMIT);
            end else begin
              add_beat(KIND_DATA, full_byte, bytes_seen, CAUSE_BAD_COMMENT);
            end
          end
          return 1'b1;
        end
        default: begin
        end
      endcase

      state = ST_SCAN;
      if (c == CH_RBRK || c == CH_SEMI || c == CH_NUL) begin
        add_beat(KIND_DONE, 8'd0, bytes_seen, CAUSE_BAD_COMMENT);
      end else if (c == CH_SLASH) begin
        state = ST_SLASH;
      end else if (!in_data) begin
        if (c == CH_LBRK) begin
          in_data = 1'b1;
        end
      end else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
        // Whitespace between pairs is skipped.
      end else if (dv < 0) begin
        add_beat(KIND_ERROR, 8'd0, bytes_seen, CAUSE_BAD_HEX);
      end else begin
        high_nibble = 4'(dv);
        state       = ST_LOW_NIBBLE;
      end
      return 1'b1;
    endfunction

    function void check_beat(logic [1:0] kind, logic [7:0] data_byte, logic [9:0] byte_count,
                             logic [1:0] error_cause);
      parse_beat_t b;
      if (pending_beats.size() == 0) begin
        report($sformatf("unexpected beat kind %0d byte %0h count %0d cause %0d",
                         kind, data_byte, byte_count, error_cause));
        return;
      end
      b = pending_beats.pop_front();
      if (kind !== b.kind) begin
        report($sformatf("kind %0d, predicted %0d", kind, b.kind));
      end
      if (data_byte !== b.data_byte) begin
        report($sformatf("data_byte %0h, predicted %0h", data_byte, b.data_byte));
      end
      if (byte_count !== b.byte_count) begin
        report($sformatf("byte_count %0d, predicted %0d", byte_count, b.byte_count));
      end
      if (error_cause !== b.error_cause) begin
        report($sformatf("error_cause %0d, predicted %0d", error_cause, b.error_cause));
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni      = 1'b0;
  logic       in_valid    = 1'b0;
  logic [7:0] char_code   = 8'd0;
  logic       new_text    = 1'b0;
  logic       out_ready   = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [1:0] kind_o;
  logic [7:0] data_byte_o;
  logic [9:0] byte_count_o;
  logic [1:0] error_cause_o;

  parse_scoreboard sb;
  logic [7:0]      text_q[$];
  int unsigned     acted_chars;
  int unsigned     burst_left;
  int unsigned     cycles = 0;

  hex_text_byte_parser i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .char_code_i   (char_code),
    .new_text_i    (new_text),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .kind_o        (kind_o),
    .data_byte_o   (data_byte_o),
    .byte_count_o  (byte_count_o),
    .error_cause_o (error_cause_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Output side. The receiver switches between stretches of full throughput,
  // random per-cycle stalls and solid stalls, each of random length.
  int unsigned stall_mode = 0;
  int unsigned stall_hold = 0;
  always @(posedge clk_i) begin
    if (stall_hold == 0) begin
      stall_mode = $urandom_range(0, 9);
      stall_hold = (stall_mode < 7) ? $urandom_range(1, 40) : $urandom_range(1, 12);
    end else begin
      stall_hold--;
    end
    if (stall_mode < 4) begin
      out_ready <= 1'b1;
    end else if (stall_mode < 7) begin
      out_ready <= 1'($urandom_range(0, 1));
    end else begin
      out_ready <= 1'b0;
    end
  end

  // Every output beat taken at this edge is checked. Inputs are driven with
  // nonblocking assignments, so the values seen here are the ones of the edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready) begin
      sb.check_beat(kind_o, data_byte_o, byte_count_o, error_cause_o);
    end
  end

  // Offers one character and holds it until the parser takes it. The sender
  // works in bursts, and valid drops between bursts.
  task automatic send_char(logic [7:0] c, logic fresh);
    in_valid  <= 1'b1;
    char_code <= c;
    new_text  <= fresh;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    acted_chars += sb.predict_char(c, fresh);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      // Now and then a long burst runs with no gap at all.
      burst_left = ($urandom_range(0, 4) == 0) ? 100 : $urandom_range(1, 30);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_string(string s, logic fresh);
    int i;
    for (i = 0; i < s.len(); i++) begin
      send_char(s[i], fresh && (i == 0));
    end
  endtask

  // Holds the sender off until every predicted beat has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic add_hex_digit();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) begin
      text_q.push_back(8'("0" + v));
    end else begin
      text_q.push_back(8'(($urandom_range(0, 1) ? "A" : "a") + v - 10));
    end
  endtask

  task automatic add_space();
    case ($urandom_range(0, 5))
      0: text_q.push_back(CH_SPACE);
      1: text_q.push_back(CH_TAB);
      2: text_q.push_back(CH_LF);
      3: text_q.push_back(CH_VT);
      4: text_q.push_back(CH_FF);
      default: text_q.push_back(CH_CR);
    endcase
  endtask

  // A comment body never holds an early terminator, so the comment stays
  // open until its proper end. With unclosed set the text ends in it by NUL.
  task automatic add_comment(bit unclosed);
    bit block;
    block = 1'($urandom_range(0, 1));
    text_q.push_back(CH_SLASH);
    text_q.push_back(block ? CH_STAR : CH_SLASH);
    repeat ($urandom_range(0, 6)) begin
      case ($urandom_range(0, 3))
        0: text_q.push_back(block ? CH_STAR : CH_SLASH);
        1: text_q.push_back(CH_SPACE);
        default: text_q.push_back(8'($urandom_range(8'h61, 8'h7a)));
      endcase
    end
    if (unclosed) begin
      text_q.push_back(CH_NUL);
    end else if (block) begin
      text_q.push_back(CH_STAR);
      text_q.push_back(CH_SLASH);
    end else begin
      text_q.push_back($urandom_range(0, 1) ? CH_LF : CH_CR);
    end
  endtask

  // Builds a well-formed text with random content, then breaks some of them:
  // a character overwritten, a character dropped, or a comment left open.
  task automatic build_text();
    int n_bytes;
    int i;
    text_q.delete();
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 4) == 0) begin
        add_comment(1'b0);
      end else begin
        text_q.push_back(8'($urandom_range(8'h61, 8'h7a)));
      end
    end
    text_q.push_back(CH_LBRK);
    n_bytes = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 10);
    for (i = 0; i < n_bytes; i++) begin
      add_hex_digit();
      add_hex_digit();
      case ($urandom_range(0, 5))
        0, 1: begin
        end
        2, 3: add_space();
        4: add_comment(1'b0);
        default: begin
          add_space();
          add_comment(1'b0);
        end
      endcase
    end
    case ($urandom_range(0, 7))
      0, 1, 2: text_q.push_back(CH_RBRK);
      3, 4: text_q.push_back(CH_SEMI);
      5, 6: text_q.push_back(CH_NUL);
      default: add_comment(1'b1);
    endcase
    case ($urandom_range(0, 9))
      0: text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
      1: text_q.delete($urandom_range(0, text_q.size() - 1));
      default: begin
      end
    endcase
    // Characters after the end are ignored by the parser.
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int i;
    int n;
    sb          = new();
    acted_chars = 0;
    burst_left  = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: end before any data, decoded bytes with both cases of
    // digits and every terminator, a bad comment start, a star that opens a
    // block comment and cannot close it, a line comment closed by CR, text
    // ending inside a hex pair or inside a comment, and a non-hex character.
    send_string("]", 1'b1);
    send_char(CH_NUL, 1'b1);
    send_string("[00 Ff;", 1'b1);
    send_string("/x", 1'b1);
    send_string("/*/*/]", 1'b1);
    send_string("x", 1'b0);
    send_string("[a", 1'b1);
    send_char(CH_NUL, 1'b0);
    send_string("/*", 1'b1);
    send_char(CH_NUL, 1'b0);
    send_string("[z", 1'b1);
    send_string("[//c", 1'b1);
    send_char(CH_CR, 1'b0);
    send_string("7e9]", 1'b0);

    wait_drained();

    // Random part: mostly built texts, the rest short bursts of raw noise; any
    // text may also restart midway.
    acted_chars = 0;
    while (acted_chars < RANDOM_CHARS) begin
      if ($urandom_range(0, 9) < 8) begin
        build_text();
      end else begin
        text_q.delete();
        repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(0, 255)));
      end
      n = text_q.size();
      for (i = 0; i < n; i++) begin
        send_char(text_q[i], (i == 0) || ($urandom_range(0, 199) == 0));
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/htbp_pkg.sv
rtl/core/htbp_classify.sv
rtl/core/htbp_fifo.sv
rtl/core/htbp_engine.sv
rtl/core/hex_text_byte_parser.sv
test/tb.sv
